FILE: design/arl_pkg.sv
// Package for the address resolving list table.
// Holds command and status codes, controller states and the cell-chain structs.
// No dependencies.
`timescale 1ns / 1ps

package arl_pkg;

    localparam int ARL_ENTRIES      = 8;
    localparam int ARL_PAYLOAD_BITS = 64;
    localparam int ARL_KEY_W        = 56;
    localparam int ARL_PAY_MAX      = 64;
    localparam int ARL_POS_W        = 7;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_CLEAR  = 3'd2;
    localparam logic [2:0] KIND_LOOKUP = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    // search token walking down the cells
    typedef struct packed {
        logic                   active;
        logic                   hit;
        logic [ARL_POS_W-1:0]   pos;
        logic [ARL_KEY_W-1:0]   key;
        logic [ARL_PAY_MAX-1:0] pay;
    } t_tok;

    // controls broadcast to every cell
    typedef struct packed {
        logic [ARL_POS_W-1:0]   count;
        logic                   read_mode;
        logic [ARL_KEY_W-1:0]   key;
        logic [ARL_POS_W-1:0]   idx;
        logic                   wr_en;
        logic [ARL_POS_W-1:0]   wr_pos;
        logic [ARL_KEY_W-1:0]   wr_key;
        logic [ARL_PAY_MAX-1:0] wr_pay;
        logic                   sh_en;
        logic [ARL_POS_W-1:0]   sh_pos;
    } t_ctl;

endpackage

FILE: design/arl_cell.sv
// One list entry of the address resolving list table.
// Holds key and payload, matches the passing token, shifts from its upper neighbor.
// Depends on arl_pkg.
`timescale 1ns / 1ps

module arl_cell
    import arl_pkg::*;
#(
    parameter int POS          = 0,
    parameter int ENTRIES      = ARL_ENTRIES,
    parameter int PAYLOAD_BITS = ARL_PAYLOAD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  t_tok                    i_tok,
    output t_tok                    o_tok,
    input  logic [ARL_KEY_W-1:0]    i_next_key,
    input  logic [PAYLOAD_BITS-1:0] i_next_pay,
    output logic [ARL_KEY_W-1:0]    o_key,
    output logic [PAYLOAD_BITS-1:0] o_pay
);

    localparam logic [ARL_POS_W-1:0] MY_POS = ARL_POS_W'(POS);

    logic [ARL_KEY_W-1:0]    r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    t_tok                    r_tok;
    t_tok                    n_tok;
    logic                    w_valid;
    logic                    w_match;
    logic                    w_shift;

    assign w_valid = MY_POS < i_ctl.count;
    assign w_match = i_tok.active && !i_tok.hit && w_valid &&
                     (i_ctl.read_mode ? (i_ctl.idx == MY_POS) : (i_ctl.key == r_key));
    assign w_shift = i_ctl.sh_en && (MY_POS >= i_ctl.sh_pos) && (POS < ENTRIES - 1);

    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.hit = 1'b1;
            n_tok.pos = MY_POS;
            n_tok.key = r_key;
            n_tok.pay = ARL_PAY_MAX'(r_pay);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= n_tok.active;
        end
        r_tok.hit <= n_tok.hit;
        r_tok.pos <= n_tok.pos;
        r_tok.key <= n_tok.key;
        r_tok.pay <= n_tok.pay;
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key <= i_next_key;
            r_pay <= i_next_pay;
        end else if (i_ctl.wr_en && (i_ctl.wr_pos == MY_POS)) begin
            r_key <= i_ctl.wr_key;
            r_pay <= PAYLOAD_BITS'(i_ctl.wr_pay);
        end
    end

    assign o_tok = r_tok;
    assign o_key = r_key;
    assign o_pay = r_pay;

endmodule

FILE: design/address_resolving_list_table.sv
// Top level of the address resolving list table: controller, result register, cell chain.
// Depends on arl_pkg and arl_cell.
//
// Add, remove, lookup and read send a search token down a chain of ENTRIES cells, one
// cell per cycle, and the result is committed once the token has left the last cell
// and the output register is free; clear, unused kinds and an add to a full list skip
// the chain. One command is in work at a time; the next beat is taken once the current
// result sits in the output register, even while that result waits for tready.
`timescale 1ns / 1ps

module address_resolving_list_table
    import arl_pkg::*;
#(
    parameter int ENTRIES      = ARL_ENTRIES,
    parameter int PAYLOAD_BITS = ARL_PAYLOAD_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // identity_key[55:0], entry_payload[119:56], entry_index[122:120], zero fill
    input  logic [127:0] s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found_index[2:0], found_key[58:3], found_payload[122:59], entry_count[126:123], zero
    output logic [127:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    t_state                  r_state;
    t_state                  n_state;
    logic [2:0]              r_kind;
    logic [ARL_KEY_W-1:0]    r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [2:0]              r_idx;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_launch;
    logic                    r_hit;
    logic [ARL_POS_W-1:0]    r_hit_pos;
    logic [ARL_KEY_W-1:0]    r_hit_key;
    logic [ARL_PAY_MAX-1:0]  r_hit_pay;

    logic                    r_out_valid;
    logic [2:0]              r_out_status;
    logic [2:0]              r_out_index;
    logic [ARL_KEY_W-1:0]    r_out_key;
    logic [ARL_PAY_MAX-1:0]  r_out_pay;
    logic [3:0]              r_out_count;

    logic                    w_accept;
    logic                    w_need_scan;
    logic                    w_out_free;
    logic                    w_commit;
    logic                    w_end;
    logic [2:0]              w_status;
    logic                    w_ret;
    t_ctl                    w_ctl;

    t_tok                    w_tok [ENTRIES+1];
    logic [ARL_KEY_W-1:0]    w_key [ENTRIES];
    logic [PAYLOAD_BITS-1:0] w_pay [ENTRIES];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_need_scan   = (s_axis_tuser == KIND_REMOVE) || (s_axis_tuser == KIND_LOOKUP) ||
                           (s_axis_tuser == KIND_READ) ||
                           ((s_axis_tuser == KIND_ADD) && (r_count < FULL_CNT));
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_commit      = (r_state == S_EXEC) && w_out_free;
    assign w_end         = w_tok[ENTRIES].active;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = w_need_scan ? S_SCAN : S_EXEC;
            S_SCAN: if (w_end) n_state = S_EXEC;
            S_EXEC: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // result of the command in work
    always_comb begin
        w_status = ST_OK;
        w_ret    = 1'b0;
        n_count  = r_count;
        case (r_kind)
            KIND_ADD: begin
                if (r_count >= FULL_CNT) begin
                    w_status = ST_FULL;
                end else if (r_hit) begin
                    w_status = ST_DUP;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (!r_hit) begin
                    w_status = ST_MISSING;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            KIND_CLEAR: n_count = '0;
            KIND_LOOKUP: begin
                if (!r_hit) w_status = ST_MISSING;
                else        w_ret    = 1'b1;
            end
            KIND_READ: begin
                if (!r_hit) w_status = ST_RANGE;
                else        w_ret    = 1'b1;
            end
            default: w_status = ST_OK;
        endcase
    end

    always_comb begin
        w_ctl           = '0;
        w_ctl.count     = ARL_POS_W'(r_count);
        w_ctl.read_mode = (r_kind == KIND_READ);
        w_ctl.key       = r_key;
        w_ctl.idx       = ARL_POS_W'(r_idx);
        w_ctl.wr_en     = w_commit && (r_kind == KIND_ADD) && (w_status == ST_OK);
        w_ctl.wr_pos    = ARL_POS_W'(r_count);
        w_ctl.wr_key    = r_key;
        w_ctl.wr_pay    = ARL_PAY_MAX'(r_pay);
        w_ctl.sh_en     = w_commit && (r_kind == KIND_REMOVE) && (w_status == ST_OK);
        w_ctl.sh_pos    = r_hit_pos;
    end

    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].active = r_launch;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [ARL_KEY_W-1:0]    w_nkey;
        logic [PAYLOAD_BITS-1:0] w_npay;
        if (g < ENTRIES - 1) begin : g_mid
            assign w_nkey = w_key[g+1];
            assign w_npay = w_pay[g+1];
        end else begin : g_last
            assign w_nkey = '0;
            assign w_npay = '0;
        end
        arl_cell #(
            .POS          (g),
            .ENTRIES      (ENTRIES),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1]),
            .i_next_key (w_nkey),
            .i_next_pay (w_npay),
            .o_key      (w_key[g]),
            .o_pay      (w_pay[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept && w_need_scan;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= s_axis_tuser;
            r_key  <= s_axis_tdata[55:0];
            r_pay  <= PAYLOAD_BITS'(s_axis_tdata[119:56]);
            r_idx  <= s_axis_tdata[122:120];
            r_hit  <= 1'b0;
        end else if ((r_state == S_SCAN) && w_end) begin
            r_hit     <= w_tok[ENTRIES].hit;
            r_hit_pos <= w_tok[ENTRIES].pos;
            r_hit_key <= w_tok[ENTRIES].key;
            r_hit_pay <= w_tok[ENTRIES].pay;
        end
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_index  <= w_ret ? r_hit_pos[2:0] : 3'd0;
            r_out_key    <= w_ret ? r_hit_key : '0;
            r_out_pay    <= w_ret ? r_hit_pay : '0;
            r_out_count  <= 4'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_pay, r_out_key, r_out_index};

endmodule

FILE: tb/sv/arl_table_checker.sv
// Checker for the address resolving list table: mirrors the list and checks every reply.
// Watches the command and reply streams of the block; depends on arl_pkg.
`timescale 1ns / 1ps

module arl_table_checker
    import arl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cmd_tvalid,
    input  logic         i_cmd_tready,
    // identity_key[55:0], entry_payload[119:56], entry_index[122:120], zero fill
    input  logic [127:0] i_cmd_tdata,
    // kind[2:0]
    input  logic [2:0]   i_cmd_tuser,
    input  logic         i_rsp_tvalid,
    input  logic         i_rsp_tready,
    // found_index[2:0], found_key[58:3], found_payload[122:59], entry_count[126:123], zero
    input  logic [127:0] i_rsp_tdata,
    // status[2:0]
    input  logic [2:0]   i_rsp_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [2:0]                  status;
        logic [2:0]                  index;
        logic [ARL_KEY_W-1:0]        key;
        logic [ARL_PAYLOAD_BITS-1:0] payload;
        logic [3:0]                  count;
    } t_reply;

    int                          list_len;
    logic [ARL_KEY_W-1:0]        key_table     [ARL_ENTRIES];
    logic [ARL_PAYLOAD_BITS-1:0] payload_table [ARL_ENTRIES];
    t_reply                      pending_replies [$];

    function automatic int find_key(input logic [ARL_KEY_W-1:0] key);
        for (int i = 0; i < list_len; i++) begin
            if (key_table[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_reply resolve_command(
        input logic [2:0]                  kind,
        input logic [ARL_KEY_W-1:0]        key,
        input logic [ARL_PAYLOAD_BITS-1:0] payload,
        input logic [2:0]                  idx
    );
        t_reply r;
        int     pos;
        r        = '0;
        r.status = ST_OK;
        case (kind)
            KIND_ADD: begin
                // full is checked before duplicate
                if (list_len >= ARL_ENTRIES) begin
                    r.status = ST_FULL;
                end else if (find_key(key) >= 0) begin
                    r.status = ST_DUP;
                end else begin
                    key_table[list_len]     = key;
                    payload_table[list_len] = payload;
                    list_len++;
                end
            end
            KIND_REMOVE: begin
                pos = find_key(key);
                if (pos < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    for (int j = pos; j + 1 < list_len; j++) begin
                        key_table[j]     = key_table[j + 1];
                        payload_table[j] = payload_table[j + 1];
                    end
                    list_len--;
                end
            end
            KIND_CLEAR: begin
                list_len = 0;
            end
            KIND_LOOKUP: begin
                pos = find_key(key);
                if (pos < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    r.index   = pos[2:0];
                    r.key     = key_table[pos];
                    r.payload = payload_table[pos];
                end
            end
            KIND_READ: begin
                if (idx >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.index   = idx;
                    r.key     = key_table[idx];
                    r.payload = payload_table[idx];
                end
            end
            default: begin
            end
        endcase
        r.count = list_len[3:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            list_len = 0;
            pending_replies.delete();
            o_fail_count = 0;
        end else begin
            // retire the reply first so a stray beat is never matched to a new command
            if (i_rsp_tvalid && i_rsp_tready) begin
                if (pending_replies.size() == 0) begin
                    $error("reply beat with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status",        64'(want.status),
                                64'(i_rsp_tuser));
                    check_field("found_index",   64'(want.index),
                                64'(i_rsp_tdata[2:0]));
                    check_field("found_key",     64'(want.key),
                                64'(i_rsp_tdata[58:3]));
                    check_field("found_payload", 64'(want.payload),
                                64'(i_rsp_tdata[122:59]));
                    check_field("entry_count",   64'(want.count),
                                64'(i_rsp_tdata[126:123]));
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                pending_replies.push_back(resolve_command(i_cmd_tuser, i_cmd_tdata[55:0],
                                                          i_cmd_tdata[119:56],
                                                          i_cmd_tdata[122:120]));
            end
        end
        o_pending = pending_replies.size();
    end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the address resolving list table: clock, reset, command and reply traffic.
// Depends on arl_pkg, address_resolving_list_table and arl_table_checker.
`timescale 1ns / 1ps

module tb;
    import arl_pkg::*;

    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_B = 3'd6;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;
    localparam int         POOL_SIZE    = 12;
    localparam int         RANDOM_CMDS  = 1350;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;
    logic [2:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b1;
    logic [127:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    int           fail_count;
    int           pending;
    bit           send_gaps     = 1'b1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    address_resolving_list_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    arl_table_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (s_axis_tvalid),
        .i_cmd_tready (s_axis_tready),
        .i_cmd_tdata  (s_axis_tdata),
        .i_cmd_tuser  (s_axis_tuser),
        .i_rsp_tvalid (m_axis_tvalid),
        .i_rsp_tready (m_axis_tready),
        .i_rsp_tdata  (m_axis_tdata),
        .i_rsp_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [ARL_KEY_W-1:0] rand_key();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ARL_KEY_W-1:0];
    endfunction

    function automatic logic [63:0] rand_payload();
        return {$urandom(), $urandom()};
    endfunction

    // called right after a rising edge; leaves tvalid high after the accepting edge
    task automatic send_cmd(input logic [2:0] kind, input logic [ARL_KEY_W-1:0] key,
                            input logic [63:0] payload, input logic [2:0] idx);
        int gap;
        bit took;
        gap = send_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, idx, payload, key};
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // command source and verdict
    initial begin
        logic [ARL_KEY_W-1:0] pool [POOL_SIZE];
        logic [ARL_KEY_W-1:0] key;
        logic [2:0]           kind;
        int                   pick;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool[i] = rand_key();
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(KIND_READ,   pool[0], rand_payload(), 3'd0);   // empty list
        send_cmd(KIND_LOOKUP, pool[0], rand_payload(), 3'd0);
        send_cmd(KIND_REMOVE, pool[0], rand_payload(), 3'd0);
        send_cmd(KIND_ADD,    '0,      '0,             3'd0);
        send_cmd(KIND_ADD,    '1,      '1,             3'd7);
        send_cmd(KIND_ADD,    '0,      rand_payload(), 3'd0);   // duplicate
        for (int i = 2; i < 8; i++) begin
            send_cmd(KIND_ADD, pool[i], rand_payload(), 3'(i));
        end
        send_cmd(KIND_ADD,    pool[9], rand_payload(), 3'd0);   // full
        send_cmd(KIND_ADD,    '0,      rand_payload(), 3'd0);   // full wins over duplicate
        send_cmd(KIND_LOOKUP, '1,      rand_payload(), 3'd0);
        send_cmd(KIND_LOOKUP, pool[7], rand_payload(), 3'd0);
        send_cmd(KIND_READ,   pool[0], rand_payload(), 3'd7);
        send_cmd(KIND_REMOVE, pool[3], rand_payload(), 3'd0);   // shifts the tail down
        send_cmd(KIND_READ,   pool[0], rand_payload(), 3'd3);
        send_cmd(KIND_REMOVE, pool[7], rand_payload(), 3'd0);   // last entry
        send_cmd(KIND_READ,   pool[0], rand_payload(), 3'd7);
        send_cmd(KIND_SPARE_A, '1, '1, 3'd7);
        send_cmd(KIND_SPARE_B, rand_key(), rand_payload(), 3'd2);
        send_cmd(KIND_SPARE_C, '0, '0, 3'd0);
        send_cmd(KIND_CLEAR,  pool[1], rand_payload(), 3'd0);
        send_cmd(KIND_READ,   pool[0], rand_payload(), 3'd0);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 150 == 0) begin
                send_gaps = $urandom_range(0, 3) != 0;
            end
            if (n > 0 && n % 120 == 0) begin
                pool[$urandom_range(0, POOL_SIZE - 1)] = rand_key();
            end
            if (n == 700) begin
                wait_drained();
            end
            key  = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : rand_key();
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                kind = KIND_ADD;
            end else if (pick < 55) begin
                kind = KIND_REMOVE;
            end else if (pick < 75) begin
                kind = KIND_LOOKUP;
            end else if (pick < 92) begin
                kind = KIND_READ;
            end else if (pick < 96) begin
                kind = KIND_CLEAR;
            end else begin
                kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
            end
            send_cmd(kind, key, rand_payload(), 3'($urandom_range(0, 7)));
        end

        wait_drained();
        repeat (24) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // reply sink with random stalls and two long hold-offs
    initial begin
        int  beats;
        int  gap;
        bit  took;
        bit  gaps_on;
        beats   = 0;
        gaps_on = 1'b1;
        @(posedge i_clk);
        forever begin
            if (beats % 150 == 0) begin
                gaps_on = $urandom_range(0, 3) != 0;
            end
            if (beats == 250 || beats == 800) begin
                gap = 400;
            end else begin
                gap = gaps_on ? $urandom_range(0, 13) : 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
            do begin
                @(negedge i_clk);
                took = m_axis_tvalid;
                @(posedge i_clk);
            end while (!took);
            beats++;
        end
    end

    initial begin
        #600000;
        $display("Some tests failed");
        $finish;
    end

endmodule
